// ----- hw/rtl/sli_pkg.sv -----
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int STAT_W   = 3;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_DELETE = 1'b1
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EVAL,
		S_PUT,
		S_RESP
	} state_t;

endpackage

// ----- hw/rtl/sli_ram.sv -----
module sli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/sorted_list_insert_delete.sv -----
// sorted list, up to CAPACITY signed words kept ascending in a single-port-read RAM.
// a full insert or a delete from an empty list goes straight to the response; an insert
// walks down from the last entry until it meets a smaller one, and a delete walks every entry.
// the read-compare loop over the RAM (fetch, then compare and move one entry)
// sets the rate: busy stays high until done, the next beat is taken the cycle after.
// reset (arst_n low) empties the list; the RAM contents are not cleared.
module sorted_list_insert_delete (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                func,
	input  logic signed [sli_pkg::DATA_W-1:0]   value,
	output logic                                busy,
	output logic                                done,
	output logic [sli_pkg::STAT_W-1:0]          status,
	output logic [sli_pkg::POS_W-1:0]           position,
	output logic [sli_pkg::COUNT_W-1:0]         count,
	output logic signed [sli_pkg::DATA_W-1:0]   head_value
);

	import sli_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	logic               func_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] head_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   pos_q;
	logic               found_q;
	status_t            status_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic [DATA_W-1:0]  ram_rdata;

	logic accept;
	logic cmp_ge;
	logic cmp_eq;
	logic at_last;
	logic is_full;
	logic is_empty;

	sli_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// compares of the RAM read word against the held operand
	assign cmp_ge = $signed(ram_rdata) >= val_q;
	assign cmp_eq = ram_rdata == val_q;

	assign accept   = start && !busy;
	assign at_last  = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
	assign is_full  = cnt_q == CNT_W'(CAPACITY);
	assign is_empty = cnt_q == '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FN_INSERT) begin
						if (is_full) state_d = S_RESP;
						else if (is_empty) state_d = S_PUT;
						else state_d = S_FETCH;
					end else begin
						if (is_empty) state_d = S_RESP;
						else state_d = S_FETCH;
					end
				end
			end
			S_FETCH: state_d = S_EVAL;
			S_EVAL: begin
				if (func_q == FN_INSERT) begin
					if (!cmp_ge || idx_q == '0) state_d = S_PUT;
					else state_d = S_FETCH;
				end else begin
					if (at_last) state_d = S_RESP;
					else state_d = S_FETCH;
				end
			end
			S_PUT:  state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and RAM write port
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_IDLE: busy = 1'b0;
			S_FETCH: ;
			S_EVAL: begin
				if (func_q == FN_INSERT) begin
					// shift the entry up one slot to open a gap
					if (cmp_ge) begin
						ram_we    = 1'b1;
						ram_waddr = idx_q + IDX_W'(1);
					end
				end else if (found_q) begin
					// close the gap left by the deleted entry
					ram_we    = 1'b1;
					ram_waddr = idx_q - IDX_W'(1);
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			S_RESP: done = 1'b1;
			default: ;
		endcase
	end

	assign status     = status_q;
	assign position   = POS_W'(pos_q);
	assign count      = COUNT_W'(cnt_q);
	assign head_value = is_empty ? '0 : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PUT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == S_EVAL && func_q == FN_DELETE && at_last
					&& (found_q || cmp_eq)) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q  <= func;
					val_q   <= value;
					found_q <= 1'b0;
					pos_q   <= '0;
					if (func == FN_INSERT) begin
						idx_q    <= IDX_W'(cnt_q - CNT_W'(1));
						status_q <= is_full ? ST_FULL : ST_INSERTED;
					end else begin
						idx_q    <= '0;
						status_q <= is_empty ? ST_EMPTY : ST_NOT_FOUND;
					end
				end
			end
			S_FETCH: ;
			S_EVAL: begin
				if (func_q == FN_INSERT) begin
					if (!cmp_ge) begin
						pos_q <= idx_q + IDX_W'(1);
					end else if (idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end else begin
					if (found_q) begin
						if (idx_q == IDX_W'(1)) head_q <= $signed(ram_rdata);
					end else if (cmp_eq) begin
						found_q <= 1'b1;
						pos_q   <= idx_q;
					end
					if (at_last && (found_q || cmp_eq)) status_q <= ST_DELETED;
					if (!at_last) idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_PUT: begin
				if (pos_q == '0) head_q <= val_q;
			end
			S_RESP: ;
			default: ;
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not raise busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (cnt_q == CNT_W'(CAPACITY)))
		else $error("full status with list not full");

	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !$past(busy)) |-> $stable(cnt_q))
		else $error("count changed while idle");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	import sli_pkg::*;

	localparam int RAND_ITEMS = 1125;
	localparam int CALM_TAIL  = 150;
	localparam int WATCHDOG   = 1000;
	localparam int DRAIN      = 40;

	localparam logic signed [DATA_W-1:0] MAXV = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] MINV = 32'sh80000000;

	typedef struct packed {
		status_t                   status;
		logic [POS_W-1:0]          position;
		logic [COUNT_W-1:0]        count;
		logic signed [DATA_W-1:0]  head;
	} list_result_t;

	typedef struct packed {
		logic                      typed_in;
		func_t                     op;
		logic signed [DATA_W-1:0]  operand;
		list_result_t              want;
	} dir_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       func = FN_INSERT;
	logic signed [DATA_W-1:0]   value = '0;
	logic                       busy;
	logic                       done;
	logic [STAT_W-1:0]          status;
	logic [POS_W-1:0]           position;
	logic [COUNT_W-1:0]         count;
	logic signed [DATA_W-1:0]   head_value;

	logic signed [DATA_W-1:0]   held_values[$];
	list_result_t               results_due[$];
	dir_row_t                   dir_tab[$];
	int                         insert_bias[5] = '{85, 15, 50, 95, 5};
	int                         mismatch_cnt = 0;
	int                         idle_cycles = 0;

	sorted_list_insert_delete i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.value      (value),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.position   (position),
		.count      (count),
		.head_value (head_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ascending list image: insert goes before the first entry not smaller
	function automatic list_result_t list_apply(func_t op, logic signed [DATA_W-1:0] operand);
		list_result_t r;
		int i;
		r.status = ST_NOT_FOUND;
		r.position = '0;
		i = 0;
		if (op == FN_INSERT) begin
			if (held_values.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				while (i < held_values.size() && held_values[i] < operand)
					i++;
				held_values.insert(i, operand);
				r.status = ST_INSERTED;
				r.position = POS_W'(i);
			end
		end else if (held_values.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			while (i < held_values.size() && held_values[i] != operand)
				i++;
			if (i < held_values.size()) begin
				held_values.delete(i);
				r.status = ST_DELETED;
				r.position = POS_W'(i);
			end
		end
		r.count = COUNT_W'(held_values.size());
		r.head = (held_values.size() != 0) ? held_values[0] : '0;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// narrow range so duplicates and delete hits are common
				return 32'($urandom_range(0, 16)) - 32'sd8;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: return MAXV;
					1: return MINV;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic issue(input func_t op, input logic signed [DATA_W-1:0] operand,
			input logic typed_in, input list_result_t want, input int gap);
		list_result_t r;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		func <= op;
		value <= operand;
		do @(posedge clk); while (busy !== 1'b0);
		r = list_apply(op, operand);
		if (typed_in)
			r = want;
		results_due.push_back(r);
	endtask

	initial begin
		func_t op;
		logic signed [DATA_W-1:0] operand;
		int gap;
		int phase;

		dir_tab.push_back('{1'b1, FN_DELETE, 32'sd0, '{ST_EMPTY, 4'd0, 5'd0, 32'sd0}});
		dir_tab.push_back('{1'b1, FN_INSERT, MAXV, '{ST_INSERTED, 4'd0, 5'd1, MAXV}});
		dir_tab.push_back('{1'b1, FN_INSERT, MINV, '{ST_INSERTED, 4'd0, 5'd2, MINV}});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd0, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd0, '0});
		dir_tab.push_back('{1'b1, FN_DELETE, 32'sd5, '{ST_NOT_FOUND, 4'd0, 5'd4, MINV}});
		dir_tab.push_back('{1'b0, FN_DELETE, MINV, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, -32'sd1, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd3, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, -32'sd3, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd100, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd2, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd2, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sh40000000, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, -32'sd100, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd7, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd1, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'shc0000000, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd50, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd8, '0});
		// list is full here
		dir_tab.push_back('{1'b0, FN_INSERT, 32'sd9, '0});
		dir_tab.push_back('{1'b0, FN_DELETE, MAXV, '0});
		dir_tab.push_back('{1'b0, FN_DELETE, 32'sd0, '0});
		dir_tab.push_back('{1'b0, FN_INSERT, MAXV, '0});
		dir_tab.push_back('{1'b0, FN_DELETE, -32'sd100, '0});

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k]) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
			issue(dir_tab[k].op, dir_tab[k].operand, dir_tab[k].typed_in, dir_tab[k].want, gap);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// most phases lean toward insert or delete so the list swings between full and empty
			phase = n / 80;
			op = ($urandom_range(0, 99) < insert_bias[phase % 5]) ? FN_INSERT : FN_DELETE;
			if (op == FN_DELETE && held_values.size() != 0 && $urandom_range(0, 99) < 65)
				operand = held_values[$urandom_range(0, held_values.size() - 1)];
			else
				operand = pick_value();
			gap = 0;
			if (n < RAND_ITEMS - CALM_TAIL && phase % 3 != 2 && $urandom_range(0, 99) < 30)
				gap = $urandom_range(1, 4);
			issue(op, operand, 1'b0, '0, gap);
		end

		@(negedge clk);
		start <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatch_cnt == 0 && results_due.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	always @(posedge clk) begin
		list_result_t seen;
		list_result_t want;
		if (arst_n && done === 1'b1) begin
			seen = '{status_t'(status), position, count, head_value};
			if (results_due.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected beat: status %0d position %0d count %0d head %0d",
						seen.status, seen.position, seen.count, seen.head);
			end else begin
				want = results_due.pop_front();
				if (seen.status !== want.status || seen.position !== want.position ||
						seen.count !== want.count || seen.head !== want.head) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp status %0d position %0d count %0d head %0d, got status %0d position %0d count %0d head %0d",
							want.status, want.position, want.count, want.head,
							seen.status, seen.position, seen.count, seen.head);
				end
			end
		end
	end

	// nothing accepted or finished for too long means the block hung
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

endmodule
